/* hw/rtl/ffba_pkg.sv */
// Shared types, constants and the control store of the first-fit block allocator.
// Used by the allocator top level and its port checker; depends on nothing.
`default_nettype none

package ffba_pkg;

  localparam int unsigned BLOCK_BYTES = 8;
  localparam int unsigned POOL_BYTES  = 512;

  localparam int unsigned BYTES_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OFFSET_W = 9;

  localparam logic [STATUS_W-1:0] ST_DONE         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_IGNORED = 2'd2;

  localparam int unsigned UPC_W = 4;

  localparam logic [UPC_W-1:0] S_CLR       = 4'd0;
  localparam logic [UPC_W-1:0] S_IDLE      = 4'd1;
  localparam logic [UPC_W-1:0] S_DISP      = 4'd2;
  localparam logic [UPC_W-1:0] S_SCAN      = 4'd3;
  localparam logic [UPC_W-1:0] S_TEST      = 4'd4;
  localparam logic [UPC_W-1:0] S_MARK      = 4'd5;
  localparam logic [UPC_W-1:0] S_NOSPACE   = 4'd6;
  localparam logic [UPC_W-1:0] S_FCHK      = 4'd7;
  localparam logic [UPC_W-1:0] S_FLOC      = 4'd8;
  localparam logic [UPC_W-1:0] S_FOWN      = 4'd9;
  localparam logic [UPC_W-1:0] S_FWALK     = 4'd10;
  localparam logic [UPC_W-1:0] S_RES_ALLOC = 4'd11;
  localparam logic [UPC_W-1:0] S_RES_IGN   = 4'd12;
  localparam logic [UPC_W-1:0] S_RES_FREE  = 4'd13;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN,
    OP_MARK,
    OP_LOCATE,
    OP_OWNER,
    OP_WALK,
    OP_RES_NOSPACE,
    OP_RES_ALLOC,
    OP_RES_FREE,
    OP_RES_IGN
  } uop_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_LAST,
    C_IN_BEAT,
    C_IS_FREE,
    C_SCAN_GO,
    C_HIT,
    C_MARK_LAST,
    C_OFF_BAD,
    C_IN_BLK,
    C_OWNER_BAD,
    C_WALK_GO,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [UPC_W-1:0] t_true;
    logic [UPC_W-1:0] t_false;
  } uword_t;

  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      S_CLR:       w = '{OP_CLEAR,       C_LAST,      S_IDLE,      S_CLR};
      S_IDLE:      w = '{OP_LOAD,        C_IN_BEAT,   S_DISP,      S_IDLE};
      S_DISP:      w = '{OP_NOP,         C_IS_FREE,   S_FCHK,      S_SCAN};
      S_SCAN:      w = '{OP_SCAN,        C_SCAN_GO,   S_SCAN,      S_TEST};
      S_TEST:      w = '{OP_NOP,         C_HIT,       S_MARK,      S_NOSPACE};
      S_MARK:      w = '{OP_MARK,        C_MARK_LAST, S_RES_ALLOC, S_MARK};
      S_NOSPACE:   w = '{OP_RES_NOSPACE, C_OUT_FREE,  S_IDLE,      S_NOSPACE};
      S_FCHK:      w = '{OP_NOP,         C_OFF_BAD,   S_RES_IGN,   S_FLOC};
      S_FLOC:      w = '{OP_LOCATE,      C_IN_BLK,    S_FOWN,      S_FLOC};
      S_FOWN:      w = '{OP_OWNER,       C_OWNER_BAD, S_RES_IGN,   S_FWALK};
      S_FWALK:     w = '{OP_WALK,        C_WALK_GO,   S_FWALK,     S_RES_FREE};
      S_RES_ALLOC: w = '{OP_RES_ALLOC,   C_OUT_FREE,  S_IDLE,      S_RES_ALLOC};
      S_RES_IGN:   w = '{OP_RES_IGN,     C_OUT_FREE,  S_IDLE,      S_RES_IGN};
      S_RES_FREE:  w = '{OP_RES_FREE,    C_OUT_FREE,  S_IDLE,      S_RES_FREE};
      default:     w = '{OP_NOP,         C_ALWAYS,    S_IDLE,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ffba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the allocator's owner map.
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/first_fit_block_allocator_unit.sv */
// Sequence: an allocate dispatches, scans the owner map for a free run, then marks it and returns;
// a free checks the offset, steps to its block, reads the owner, then clears the owner's blocks.
// Throughput: one request at a time; the owner-map scan and walk read one entry per cycle.
// Reset: a clearing pass writes every owner entry to free, with s_axis_tready_o low until it ends.
// Depends on ffba_pkg and ffba_ram; control is a microcoded sequencer over a small datapath.
`default_nettype none

module first_fit_block_allocator_unit #(
  parameter int unsigned BLOCK_BYTES = ffba_pkg::BLOCK_BYTES,
  parameter int unsigned POOL_BYTES  = ffba_pkg::POOL_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // request_bytes[15:0], byte_offset[31:16]
  input  wire logic        s_axis_tuser_i,   // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o,   // start_offset[8:0], zero[15:9]
  output logic      [1:0]  m_axis_tuser_o    // status
);

  localparam int unsigned BLOCK_COUNT = POOL_BYTES / BLOCK_BYTES;
  localparam int unsigned IDX_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned CNT_W       = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned OWN_W       = CNT_W;
  localparam int unsigned USED_BYTES  = BLOCK_COUNT * BLOCK_BYTES;
  localparam int unsigned RB_W        = $clog2(USED_BYTES + BLOCK_BYTES + 1);
  localparam int unsigned CMP_W       = (RB_W > 17) ? RB_W : 17;
  localparam int unsigned BYTES_W     = ffba_pkg::BYTES_W;
  localparam int unsigned OFFSET_W    = ffba_pkg::OFFSET_W;
  localparam int unsigned STATUS_W    = ffba_pkg::STATUS_W;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(BLOCK_COUNT - 1);
  localparam logic [CNT_W-1:0] COUNT_C  = CNT_W'(BLOCK_COUNT);
  localparam logic [RB_W-1:0]  BB_C     = RB_W'(BLOCK_BYTES);
  localparam logic [CMP_W-1:0] USED_C   = CMP_W'(USED_BYTES);

  logic [ffba_pkg::UPC_W-1:0] upc_q, upc_d;
  logic [CNT_W-1:0]           idx_q, idx_d;
  logic [CNT_W-1:0]           last_q, last_d;
  logic [RB_W-1:0]            base_q, base_d;
  logic [RB_W-1:0]            run_q, run_d;
  logic [IDX_W-1:0]           first_q, first_d;
  logic [RB_W-1:0]            first_base_q, first_base_d;
  logic                       hit_q, hit_d;
  logic [OWN_W-1:0]           owner_q, owner_d;
  logic                       free_q, free_d;
  logic [BYTES_W-1:0]         req_q, req_d;
  logic [BYTES_W-1:0]         off_q, off_d;
  logic                       out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]        out_status_q, out_status_d;
  logic [OFFSET_W-1:0]        out_offset_q, out_offset_d;

  ffba_pkg::uword_t uword;
  logic             cond_ok;
  logic             in_beat;
  logic             out_free;
  logic             cell_free;
  logic [RB_W-1:0]  run_n;
  logic             hit_n;
  logic [IDX_W-1:0] first_n;
  logic [CNT_W-1:0] idx_inc;
  logic             at_last;
  logic             in_blk;
  logic             owner_bad;
  logic             owner_eq;

  logic             wr_en;
  logic [OWN_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [OWN_W-1:0] rd_data;

  ffba_ram #(
    .WIDTH (OWN_W),
    .DEPTH (BLOCK_COUNT)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx_q[IDX_W-1:0]),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign uword     = ffba_pkg::ucode(upc_q);
  assign in_beat   = s_axis_tvalid_i && (upc_q == ffba_pkg::S_IDLE);
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign cell_free = (rd_data == '0);
  assign run_n     = cell_free ? (run_q + BB_C) : '0;
  assign hit_n     = cell_free && (CMP_W'(run_n) >= CMP_W'(req_q));
  assign first_n   = (cell_free && (run_q == '0)) ? idx_q[IDX_W-1:0] : first_q;
  assign idx_inc   = idx_q + 1'b1;
  assign at_last   = (idx_q == LAST_IDX);
  assign in_blk    = CMP_W'(off_q) < (CMP_W'(base_q) + CMP_W'(BB_C));
  assign owner_bad = (rd_data == '0) || (rd_data > COUNT_C);
  assign owner_eq  = (rd_data == owner_q);
  assign rd_addr   = (idx_d < COUNT_C) ? idx_d[IDX_W-1:0] : '0;

  always_comb begin
    case (uword.cond)
      ffba_pkg::C_ALWAYS:    cond_ok = 1'b1;
      ffba_pkg::C_LAST:      cond_ok = at_last;
      ffba_pkg::C_IN_BEAT:   cond_ok = in_beat;
      ffba_pkg::C_IS_FREE:   cond_ok = free_q;
      ffba_pkg::C_SCAN_GO:   cond_ok = !hit_n && !at_last;
      ffba_pkg::C_HIT:       cond_ok = hit_q;
      ffba_pkg::C_MARK_LAST: cond_ok = (idx_q == last_q);
      ffba_pkg::C_OFF_BAD:   cond_ok = (CMP_W'(off_q) >= USED_C);
      ffba_pkg::C_IN_BLK:    cond_ok = in_blk;
      ffba_pkg::C_OWNER_BAD: cond_ok = owner_bad;
      ffba_pkg::C_WALK_GO:   cond_ok = owner_eq && !at_last;
      ffba_pkg::C_OUT_FREE:  cond_ok = out_free;
      default:               cond_ok = 1'b0;
    endcase
    upc_d = cond_ok ? uword.t_true : uword.t_false;
  end

  always_comb begin
    idx_d        = idx_q;
    last_d       = last_q;
    base_d       = base_q;
    run_d        = run_q;
    first_d      = first_q;
    first_base_d = first_base_q;
    hit_d        = hit_q;
    owner_d      = owner_q;
    free_d       = free_q;
    req_d        = req_q;
    off_d        = off_q;
    wr_en        = 1'b0;
    wr_data      = '0;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_offset_d = out_offset_q;
    case (uword.op)
      ffba_pkg::OP_CLEAR: begin
        wr_en = 1'b1;
        idx_d = idx_inc;
      end
      ffba_pkg::OP_LOAD: begin
        idx_d  = '0;
        base_d = '0;
        run_d  = '0;
        hit_d  = 1'b0;
        if (in_beat) begin
          free_d = s_axis_tuser_i;
          req_d  = (s_axis_tdata_i[15:0] == 16'd0) ? 16'd1 : s_axis_tdata_i[15:0];
          off_d  = s_axis_tdata_i[31:16];
        end
      end
      ffba_pkg::OP_SCAN: begin
        base_d  = base_q + BB_C;
        run_d   = run_n;
        first_d = first_n;
        if (cell_free && (run_q == '0)) begin
          first_base_d = base_q;
        end
        if (hit_n) begin
          hit_d  = 1'b1;
          last_d = idx_q;
          idx_d  = CNT_W'(first_n);
        end else begin
          idx_d = idx_inc;
        end
      end
      ffba_pkg::OP_MARK: begin
        wr_en   = 1'b1;
        wr_data = OWN_W'(first_q) + 1'b1;
        idx_d   = idx_inc;
      end
      ffba_pkg::OP_LOCATE: begin
        if (!in_blk) begin
          idx_d  = idx_inc;
          base_d = base_q + BB_C;
        end
      end
      ffba_pkg::OP_OWNER: begin
        owner_d = rd_data;
        idx_d   = rd_data - 1'b1;
      end
      ffba_pkg::OP_WALK: begin
        if (owner_eq) begin
          wr_en = 1'b1;
          idx_d = idx_inc;
        end
      end
      ffba_pkg::OP_RES_NOSPACE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ffba_pkg::ST_NO_SPACE;
          out_offset_d = '0;
        end
      end
      ffba_pkg::OP_RES_ALLOC: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ffba_pkg::ST_DONE;
          out_offset_d = OFFSET_W'(first_base_q);
        end
      end
      ffba_pkg::OP_RES_FREE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ffba_pkg::ST_DONE;
          out_offset_d = '0;
        end
      end
      ffba_pkg::OP_RES_IGN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ffba_pkg::ST_FREE_IGNORED;
          out_offset_d = '0;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ffba_pkg::S_CLR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    base_q       <= base_d;
    run_q        <= run_d;
    first_q      <= first_d;
    first_base_q <= first_base_d;
    hit_q        <= hit_d;
    owner_q      <= owner_d;
    free_q       <= free_d;
    req_q        <= req_d;
    off_q        <= off_d;
    out_status_q <= out_status_d;
    out_offset_q <= out_offset_d;
  end

  assign s_axis_tready_o = (upc_q == ffba_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(16 - OFFSET_W){1'b0}}, out_offset_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

`default_nettype wire

/* hw/rtl/ffba_chk.sv */
// Port checker for the first-fit block allocator, bound to its top level.
// Depends on ffba_pkg for the status codes.
`default_nettype none

module ffba_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  logic in_beat;

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed under stall");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tuser_o == ffba_pkg::ST_DONE) || (m_axis_tuser_o == ffba_pkg::ST_NO_SPACE) ||
      (m_axis_tuser_o == ffba_pkg::ST_FREE_IGNORED))
    else $error("undefined status code");

  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ffba_pkg::ST_DONE) |-> (m_axis_tdata_o == 16'd0))
    else $error("offset not zero on a failed request");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("request taken while another is in work");

endmodule

bind first_fit_block_allocator_unit ffba_chk u_ffba_chk (.*);

`default_nettype wire
